// ----- design/ffha_pkg.sv -----
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned OFF_W = 21;
  localparam int unsigned REQ_W = 20;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CHUNK = 8;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOMEM   = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_NOTBLK  = 3'd3,
    ST_NOTUSE  = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RD_M,
    RD_RLINK,
    RD_CLINK
  } rd_src_e;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_ALLOC,
    WR_CUR
  } wr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_CHK,
    S_A_SCAN,
    S_A_WNEW,
    S_A_WCUR,
    S_F_CHK,
    S_F_WCLR,
    S_M_START,
    S_M_CAP,
    S_M_NXT,
    S_M_USED,
    S_M_WB,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_src_e rd_src;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cap_cur;
    logic    clr_use;
    logic    m_from_r;
    logic    m_from_c;
    logic    m_zero;
    logic    scan_start;
    logic    scan_step;
    logic    take_slot;
    logic    merge;
    logic    set_res;
    status_e res_code;
    logic    res_off;
    logic    out_load;
  } ffha_cmd_t;

  typedef struct packed {
    logic op_free;
    logic above;
    logic fit;
    logic last;
    logic match;
    logic r_used;
    logic r_link_end;
    logic c_link_end;
    logic scan_found;
    logic scan_done;
    logic out_busy;
  } ffha_sts_t;

endpackage

// ----- design/ffha_in_if.sv -----
// Request channel: op, request size and payload offset.
interface ffha_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [ffha_pkg::REQ_W-1:0]   request_bytes;
  logic [ffha_pkg::OFF_W-1:0]   payload_offset;
  modport source (output valid, op, request_bytes, payload_offset, input ready);
  modport sink   (input valid, op, request_bytes, payload_offset, output ready);
endinterface

// ----- design/ffha_out_if.sv -----
// Result channel: payload offset and status.
interface ffha_out_if;
  logic                        valid;
  logic                        ready;
  logic [ffha_pkg::OFF_W-1:0]  result_offset;
  logic [ffha_pkg::ST_W-1:0]   status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

// ----- design/ffha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/ffha_ctrl.sv -----
// Sequencer for allocate, free and merge walks over the block chain.
module ffha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffha_pkg::ffha_sts_t sts_i,
  output ffha_pkg::ffha_cmd_t cmd_o
);
  import ffha_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_code = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op_free && sts_i.above) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_OUTSIDE;
          state_d        = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_M;
          state_d      = sts_i.op_free ? S_F_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        cmd_o.cap_cur = 1'b1;
        if (sts_i.fit) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_A_SCAN;
        end else if (sts_i.last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NOMEM;
          state_d        = S_FINISH;
        end else begin
          cmd_o.m_from_r = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_RLINK;
        end
      end
      S_A_SCAN: begin
        if (sts_i.scan_found) begin
          cmd_o.take_slot = 1'b1;
          state_d         = S_A_WNEW;
        end else if (sts_i.scan_done) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_FULL;
          state_d        = S_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_A_WNEW: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_NEW;
        state_d      = S_A_WCUR;
      end
      S_A_WCUR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_ALLOC;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_code = ST_OK;
        cmd_o.res_off  = 1'b1;
        state_d        = S_FINISH;
      end
      S_F_CHK: begin
        cmd_o.cap_cur = 1'b1;
        if (sts_i.match) begin
          if (sts_i.r_used) begin
            cmd_o.clr_use = 1'b1;
            state_d       = S_F_WCLR;
          end else begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = ST_NOTUSE;
            state_d        = S_FINISH;
          end
        end else if (sts_i.last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NOTBLK;
          state_d        = S_FINISH;
        end else begin
          cmd_o.m_from_r = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_RLINK;
        end
      end
      S_F_WCLR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CUR;
        cmd_o.m_zero = 1'b1;
        state_d      = S_M_START;
      end
      S_M_START: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_M;
        state_d      = S_M_CAP;
      end
      S_M_CAP: begin
        cmd_o.cap_cur = 1'b1;
        if (sts_i.r_link_end) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_FINISH;
        end else if (sts_i.r_used) begin
          cmd_o.m_from_r = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_RLINK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_RLINK;
          state_d      = S_M_NXT;
        end
      end
      S_M_NXT: begin
        if (!sts_i.r_used) begin
          // absorb the free neighbor and look at the one after it
          cmd_o.merge = 1'b1;
          if (sts_i.r_link_end) begin
            state_d = S_M_WB;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = RD_RLINK;
          end
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_CUR;
          cmd_o.m_from_c = 1'b1;
          cmd_o.cap_cur  = 1'b1;
          state_d        = S_M_USED;
        end
      end
      S_M_USED: begin
        if (sts_i.c_link_end) begin
          cmd_o.set_res = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.m_from_c = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_CLINK;
          state_d        = S_M_CAP;
        end
      end
      S_M_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_CUR;
        cmd_o.set_res = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- design/ffha_dp.sv -----
// Datapath: block table RAM, slot map, walk registers and result register.
module ffha_dp #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ADDR_BITS    = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffha_pkg::OFF_W-1:0]  cfg_wdata_i,
  input  logic                        op_i,
  input  logic [ffha_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [ffha_pkg::OFF_W-1:0]  payload_offset_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ffha_pkg::OFF_W-1:0]  result_offset_o,
  output logic [ffha_pkg::ST_W-1:0]   status_o,
  input  ffha_pkg::ffha_cmd_t         cmd_i,
  output ffha_pkg::ffha_sts_t         sts_o
);
  import ffha_pkg::*;

  localparam int unsigned IW      = $clog2(MAX_BLOCKS);
  localparam int unsigned LW      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ENTRY_W = 2 * OFF_W + 1 + LW;
  localparam int unsigned NCHUNK  = (MAX_BLOCKS + CHUNK - 1) / CHUNK;
  localparam int unsigned CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PADW    = NCHUNK * CHUNK;
  localparam logic [LW-1:0]    END_LINK = LW'(MAX_BLOCKS);
  localparam logic [OFF_W-1:0] HDR      = OFF_W'(HEADER_BYTES);
  localparam logic [32:0]      TOP      = 33'(1) << ADDR_BITS;
  // 1 MiB at reset, clamped to the address range
  localparam logic [OFF_W-1:0] RST_HEAP = (TOP > 33'(1048576)) ? OFF_W'(1048576)
                                                                 : TOP[OFF_W-1:0];

  // table entry: start, bytes, used, link
  logic [OFF_W-1:0] r_start, r_bytes, c_start_q, c_bytes_q;
  logic             r_used, c_used_q;
  logic [LW-1:0]    r_link, c_link_q;
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [IW-1:0]    raddr, waddr;

  logic [OFF_W-1:0] heap_q;
  logic             fresh_q, rd_fresh_q;
  logic [MAX_BLOCKS-1:0] taken_q;
  logic [IW-1:0]    m_q, n_q;
  logic [IW-1:0]    steps_q;
  logic [CW-1:0]    chunk_q;
  logic             op_q;
  logic [REQ_W-1:0] req_q;
  logic [OFF_W-1:0] poff_q;
  status_e          res_code_q;
  logic [OFF_W-1:0] res_off_q;
  logic             out_valid_q;
  logic [OFF_W-1:0] out_off_q;
  logic [ST_W-1:0]  out_st_q;

  logic [OFF_W-1:0] cfg_lo, cfg_hs;

  assign cfg_lo = (cfg_wdata_i < OFF_W'(64)) ? OFF_W'(64) : cfg_wdata_i;
  assign cfg_hs = (33'(cfg_lo) > TOP) ? TOP[OFF_W-1:0] : cfg_lo;

  ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // head slot reads as the initial block until it is first written
  always_comb begin
    if (rd_fresh_q) begin
      r_start = '0;
      r_bytes = heap_q - HDR;
      r_used  = 1'b0;
      r_link  = END_LINK;
    end else begin
      r_start = rdata[ENTRY_W-1 -: OFF_W];
      r_bytes = rdata[LW+1 +: OFF_W];
      r_used  = rdata[LW];
      r_link  = rdata[LW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.rd_src)
      RD_RLINK: raddr = r_link[IW-1:0];
      RD_CLINK: raddr = c_link_q[IW-1:0];
      default:  raddr = m_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_NEW: begin
        waddr = n_q;
        wdata = {c_start_q + HDR + OFF_W'(req_q), c_bytes_q - OFF_W'(req_q) - HDR,
                 1'b0, c_link_q};
      end
      WR_ALLOC: begin
        waddr = m_q;
        wdata = {c_start_q, OFF_W'(req_q), 1'b1, LW'(n_q)};
      end
      default: begin
        waddr = m_q;
        wdata = {c_start_q, c_bytes_q, c_used_q, c_link_q};
      end
    endcase
  end

  // free slot search, one chunk of the slot map per cycle
  logic [PADW-1:0]  taken_pad;
  logic [CHUNK-1:0] chunk_bits;
  logic             scan_found;
  logic [2:0]       scan_pos;

  assign taken_pad  = {{(PADW - MAX_BLOCKS){1'b1}}, taken_q};
  assign chunk_bits = taken_pad[chunk_q * CHUNK +: CHUNK];

  always_comb begin
    scan_found = 1'b0;
    scan_pos   = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (!chunk_bits[j]) begin
        scan_found = 1'b1;
        scan_pos   = 3'(j);
      end
    end
  end

  always_comb begin
    sts_o.op_free    = op_q;
    sts_o.above      = poff_q > heap_q;
    sts_o.fit        = !r_used && ({1'b0, r_bytes} >= ({2'b0, req_q} + {1'b0, HDR}));
    sts_o.last       = (r_link == END_LINK) || (steps_q == IW'(MAX_BLOCKS - 1));
    sts_o.match      = ({1'b0, r_start} + {1'b0, HDR}) == {1'b0, poff_q};
    sts_o.r_used     = r_used;
    sts_o.r_link_end = r_link == END_LINK;
    sts_o.c_link_end = c_link_q == END_LINK;
    sts_o.scan_found = scan_found;
    sts_o.scan_done  = chunk_q == CW'(NCHUNK - 1);
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= RST_HEAP;
      fresh_q     <= 1'b1;
      rd_fresh_q  <= 1'b0;
      taken_q     <= MAX_BLOCKS'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_q  <= cfg_hs;
        fresh_q <= 1'b1;
        taken_q <= MAX_BLOCKS'(1);
      end else begin
        if (cmd_i.wr_en && waddr == '0) begin
          fresh_q <= 1'b0;
        end
        if (cmd_i.take_slot) begin
          taken_q[IW'({chunk_q, scan_pos})] <= 1'b1;
        end
        if (cmd_i.merge) begin
          taken_q[c_link_q[IW-1:0]] <= 1'b0;
        end
      end
      if (cmd_i.rd_en) begin
        rd_fresh_q <= fresh_q && (raddr == '0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      req_q   <= request_bytes_i;
      poff_q  <= payload_offset_i;
      m_q     <= '0;
      steps_q <= '0;
    end
    if (cmd_i.m_zero) begin
      m_q <= '0;
    end
    if (cmd_i.m_from_r) begin
      m_q     <= r_link[IW-1:0];
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.m_from_c) begin
      m_q <= c_link_q[IW-1:0];
    end
    if (cmd_i.cap_cur) begin
      c_start_q <= r_start;
      c_bytes_q <= r_bytes;
      c_used_q  <= r_used && !cmd_i.clr_use;
      c_link_q  <= r_link;
    end
    if (cmd_i.merge) begin
      c_bytes_q <= c_bytes_q + HDR + r_bytes;
      c_link_q  <= r_link;
    end
    if (cmd_i.scan_start) begin
      chunk_q <= '0;
    end
    if (cmd_i.scan_step) begin
      chunk_q <= chunk_q + 1'b1;
    end
    if (cmd_i.take_slot) begin
      n_q <= IW'({chunk_q, scan_pos});
    end
    if (cmd_i.set_res) begin
      res_code_q <= cmd_i.res_code;
      res_off_q  <= cmd_i.res_off ? (c_start_q + HDR) : '0;
    end
    if (cmd_i.out_load) begin
      out_off_q <= res_off_q;
      out_st_q  <= res_code_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_offset_o = out_off_q;
  assign status_o        = out_st_q;
endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator with free-block merging.
//
// Requests arrive on in_i as words of op, request_bytes and payload_offset;
// each produces exactly one result word on out_o (result_offset, status).
// Words move on valid and ready both high. cfg_we_i writes heap_size,
// clamped to 64 .. 2^ADDR_BITS, and rebuilds the heap as one free block.
// An allocate walks the block chain, one table read per block, then scans
// the slot map for a free slot, chunk by chunk, eight slots a chunk.
// A free walks the chain to the block it names; one that succeeds then
// runs a merge walk over the chain that absorbs each free neighbor.
// The block table has a single read port; one request is in flight at a
// time, and a new one can be taken in the cycle after the previous result
// is loaded into the output register.
// Reset leaves one free block at offset 0 covering 1 MiB (2^ADDR_BITS if
// smaller), with no clearing pass. When the receiver stalls, the result
// waits in the output register; the next request may be taken and runs to
// completion, then holds until the output register frees up.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ADDR_BITS    = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffha_pkg::OFF_W-1:0] cfg_wdata_i,
  ffha_in_if.sink                    in_i,
  ffha_out_if.source                 out_o
);
  import ffha_pkg::*;

  ffha_cmd_t cmd;
  ffha_sts_t sts;
  logic      in_ready;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (in_i.op),
    .request_bytes_i  (in_i.request_bytes),
    .payload_offset_i (in_i.payload_offset),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .result_offset_o  (out_o.result_offset),
    .status_o         (out_o.status),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  assign in_i.ready = in_ready;
endmodule

// ----- dv/tb_first_fit_heap_allocator.sv -----
// Testbench for the first-fit heap allocator: model-based scoreboard, random handshakes.
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR  = 16;
  localparam int TOP  = 1 << 20;
  localparam int LIMIT = 3000000;

  class alloc_scoreboard;
    int unsigned heap_bytes;
    int unsigned b_start[NBLK];
    int unsigned b_bytes[NBLK];
    bit          b_used[NBLK];
    int unsigned b_link[NBLK];
    bit          b_taken[NBLK];
    logic [OFF_W-1:0] exp_off[$];
    status_e          exp_st[$];
    int errors;
    int live_off[$];

    function void rebuild(int unsigned sz);
      heap_bytes = (sz < 64) ? 64 : (sz > TOP ? TOP : sz);
      for (int i = 0; i < NBLK; i++) begin
        b_start[i] = 0; b_bytes[i] = 0; b_used[i] = 0;
        b_link[i] = NBLK; b_taken[i] = 0;
      end
      b_bytes[0] = heap_bytes - HDR;
      b_taken[0] = 1;
      live_off.delete();
    endfunction

    function void note_request(op_e op, int unsigned req, int unsigned p);
      int unsigned m, n, steps, found;
      status_e st;
      logic [OFF_W-1:0] off;
      st = ST_NOMEM; off = '0;
      if (op == OP_ALLOC) begin
        m = 0; steps = 0;
        while (m != NBLK && steps < NBLK) begin
          if (!b_used[m] && b_bytes[m] >= req + HDR) begin
            n = NBLK;
            for (int i = 0; i < NBLK; i++)
              if (!b_taken[i] && n == NBLK) n = i;
            if (n == NBLK) st = ST_FULL;
            else begin
              b_taken[n] = 1;
              b_start[n] = b_start[m] + HDR + req;
              b_bytes[n] = b_bytes[m] - req - HDR;
              b_used[n] = 0;
              b_link[n] = b_link[m];
              b_used[m] = 1;
              b_link[m] = n;
              b_bytes[m] = req;
              off = b_start[m] + HDR;
              live_off.push_back(off);
              st = ST_OK;
            end
            break;
          end
          m = b_link[m]; steps++;
        end
      end else if (p > heap_bytes) st = ST_OUTSIDE;
      else begin
        m = 0; steps = 0; found = NBLK;
        while (m != NBLK && steps < NBLK) begin
          if (b_start[m] + HDR == p) begin found = m; break; end
          m = b_link[m]; steps++;
        end
        if (found == NBLK) st = ST_NOTBLK;
        else if (!b_used[found]) st = ST_NOTUSE;
        else begin
          b_used[found] = 0;
          m = 0; steps = 0;
          while (m != NBLK && steps < NBLK) begin
            n = b_link[m];
            while (!b_used[m] && n != NBLK && !b_used[n]) begin
              b_bytes[m] += HDR + b_bytes[n];
              b_link[m] = b_link[n];
              b_taken[n] = 0;
              b_link[n] = NBLK;
              n = b_link[m];
            end
            m = n; steps++;
          end
          st = ST_OK;
        end
      end
      exp_off.push_back(off);
      exp_st.push_back(st);
    endfunction

    function void check_result(logic [OFF_W-1:0] off, logic [ST_W-1:0] st);
      if (exp_st.size() == 0) begin
        $display("%0t: unexpected result off=%0d status=%0d", $time, off, st);
        errors++;
        return;
      end
      if (off !== exp_off[0] || st !== exp_st[0]) begin
        $display("%0t: mismatch expected off=%0d status=%0d actual off=%0d status=%0d",
                 $time, exp_off[0], exp_st[0], off, st);
        errors++;
      end
      void'(exp_off.pop_front());
      void'(exp_st.pop_front());
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i;
  logic [OFF_W-1:0] cfg_wdata_i;
  ffha_in_if  req_ch();
  ffha_out_if res_ch();

  first_fit_heap_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(req_ch.sink), .out_o(res_ch.source)
  );

  alloc_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int hold_off;
  int cycles;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: sample at rising edge, change ready at falling edge
  always @(posedge clk_i)
    if (rst_ni && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.result_offset, res_ch.status);

  initial begin
    res_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        res_ch.ready <= 0;
      end else
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays up between back-to-back words; idle gaps and drain() drop it
  task automatic send_word(op_e op, int unsigned req, int unsigned p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.op <= op;
    req_ch.request_bytes <= req[REQ_W-1:0];
    req_ch.payload_offset <= p[OFF_W-1:0];
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(op, req, p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (sb.exp_st.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_heap(int unsigned sz);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= sz[OFF_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.rebuild(sz[OFF_W-1:0]);
  endtask

  task automatic random_word(int unsigned heap);
    int unsigned r, p, req;
    r = $urandom_range(99);
    if (r < 50) begin
      req = ($urandom_range(9) == 0) ? $urandom() & 20'hFFFFF
                                     : $urandom_range(heap / 8);
      send_word(OP_ALLOC, req, $urandom() & 21'h1FFFFF);
    end else if (r < 88 && sb.live_off.size() != 0) begin
      p = $urandom_range(sb.live_off.size() - 1);
      send_word(OP_FREE, $urandom() & 20'hFFFFF, sb.live_off[p]);
      if ($urandom_range(3) != 0) sb.live_off.delete(p);
    end else
      send_word(OP_FREE, $urandom() & 20'hFFFFF,
                ($urandom_range(1)) ? $urandom() & 21'h1FFFFF : $urandom_range(heap + 32));
  endtask

  initial begin
    int unsigned sizes[5];
    sb = new();
    sb.rebuild(TOP);
    rst_ni = 0; cfg_we_i = 0; cfg_wdata_i = '0;
    req_ch.valid = 0; req_ch.op = 0; req_ch.request_bytes = '0; req_ch.payload_offset = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: extremes, every status code
    send_word(OP_ALLOC, 20'hFFFFF, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 100, 0);
    send_word(OP_FREE, 0, 21'h1FFFFF);
    send_word(OP_FREE, 0, TOP);
    send_word(OP_FREE, 0, 17);
    send_word(OP_FREE, 0, 32);
    send_word(OP_FREE, 0, 32);
    send_word(OP_FREE, 0, 16);
    send_word(OP_FREE, 0, 16);
    set_heap(0);
    send_word(OP_ALLOC, 32, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_FREE, 0, 64);
    set_heap(21'h1FFFFF);
    // fill the block table
    for (int i = 0; i < 66; i++) send_word(OP_ALLOC, i & 3, 0);
    send_word(OP_FREE, 0, 16);
    send_word(OP_FREE, 0, 32);

    sizes = '{64, 4096, 777, TOP, 200};
    for (int ph = 0; ph < 5; ph++) begin
      set_heap(sizes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 4) hold_off = 400;
      for (int k = 0; k < 115; k++) random_word(sb.heap_bytes);
    end
    drain();
    if (sb.errors == 0 && sb.exp_st.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
